@@ hdl/rc5_pkg.sv @@
`default_nettype none

package rc5_pkg;

    // Word size of the cipher and the rotation amount taken from a word.
    localparam int WORD_W = 32;
    localparam int ROT_W  = 5;

    // Key schedule constants and the number of key words.
    localparam logic [WORD_W-1:0] MAGIC_P   = 32'hB7E15163;
    localparam logic [WORD_W-1:0] MAGIC_Q   = 32'h9E3779B9;
    localparam int                KEY_WORDS = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;

    // Move of the subkey ring in one cycle.
    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'b00,
        SHIFT_FWD  = 2'b01,
        SHIFT_BACK = 2'b10
    } shift_mode_t;

    // Control handed from the sequencer to the subkey ring.
    typedef struct packed {
        shift_mode_t mode;
        logic        insert;
    } ring_ctrl_t;

    // Rotate left by the low five bits of the amount.
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << n;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    // Rotate right by the low five bits of the amount.
    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} >> n;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/rc5_block_cipher.sv @@
// Each block runs through the round sequencer one half-round per cycle, stalling on its
// last half-round while the output register is full; it is accepted in the idle state first.
// One block is in work at a time, so a new block is taken only once the last one has left
// the round sequencer; the result waits in an output register while the next block is already being worked on.
// After reset, and after every key register write, the key schedule runs (table fill, then
// key mixing) and no block is accepted until it is done; keys reset to zero.
`default_nettype none

module rc5_block_cipher
    import rc5_pkg::*;
#(
    parameter int ROUNDS = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Block input: tdata = word_a [31:0], word_b [63:32]; tuser = func [0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    // Result output: tdata = out_a [31:0], out_b [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,
    // Key registers
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int N     = 2 * ROUNDS + 2;
    localparam int CNT_W = $clog2(3 * N);

    localparam logic [CNT_W-1:0] CNT_LAST_RUN  = CNT_W'(N - 1);
    localparam logic [CNT_W-1:0] CNT_LAST_MIX  = CNT_W'(3 * N - 1);
    localparam logic [CNT_W-1:0] CNT_DEC_WHITE = CNT_W'(N - 2);
    localparam logic [CNT_W-1:0] CNT_ENC_WHITE = CNT_W'(2);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_MIX_A = 5'b00100,
        ST_MIX_B = 5'b01000,
        ST_RUN   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] gen_reg, gen_next;
    logic [63:0]       key_lo_reg, key_hi_reg;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;
    logic [WORD_W-1:0] wa_reg, wa_next;
    logic [WORD_W-1:0] wb_reg, wb_next;
    logic              func_reg, func_next;
    logic [WORD_W-1:0] kw_reg  [KEY_WORDS];
    logic [WORD_W-1:0] kw_next [KEY_WORDS];

    ring_ctrl_t        ring_ctrl;
    logic [WORD_W-1:0] ring_ins;
    logic [WORD_W-1:0] head_word, tail_word;

    logic              cfg_hit;
    logic              in_beat;
    logic              run_last;
    logic              advance;
    logic [WORD_W-1:0] sk;
    logic              white;
    logic [WORD_W-1:0] rd_a, rd_b;
    logic [WORD_W-1:0] ab_sum, mix_a, mix_b;

    // Key register writes; any write to a valid index restarts the schedule.
    assign cfg_hit = cfg_we && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= '0;
            key_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_LOW:  key_lo_reg <= cfg_data;
                REG_KEY_HIGH: key_hi_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Handshake terms.
    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A round step stalls only on its last step, while the result register is full and not being read.
    assign run_last = (state_reg == ST_RUN) && (cnt_reg == CNT_LAST_RUN);
    assign advance  = !(run_last && out_valid_reg && !m_tready);

    // Half-round datapath: one subkey word per cycle while not stalled, taken from the head when
    // encrypting and from the tail when decrypting.
    assign sk    = func_reg ? tail_word : head_word;
    assign white = func_reg ? (cnt_reg >= CNT_DEC_WHITE) : (cnt_reg < CNT_ENC_WHITE);

    always_comb
    begin
        rd_a = wa_reg;
        rd_b = wb_reg;
        if (!func_reg)
        begin
            if (!cnt_reg[0])
                rd_a = (white ? wa_reg : rotl32(wa_reg ^ wb_reg, wb_reg[ROT_W-1:0])) + sk;
            else
                rd_b = (white ? wb_reg : rotl32(wb_reg ^ wa_reg, wa_reg[ROT_W-1:0])) + sk;
        end
        else
        begin
            if (!cnt_reg[0])
                rd_b = white ? (wb_reg - sk)
                             : (rotr32(wb_reg - sk, wa_reg[ROT_W-1:0]) ^ wa_reg);
            else
                rd_a = white ? (wa_reg - sk)
                             : (rotr32(wa_reg - sk, wb_reg[ROT_W-1:0]) ^ wb_reg);
        end
    end

    // Key mixing datapath: the A half is taken in ST_MIX_A and the B half in ST_MIX_B.
    assign ab_sum = wa_reg + wb_reg;
    assign mix_a  = rotl32(head_word + ab_sum, ROT_W'(3));
    assign mix_b  = rotl32(kw_reg[0] + ab_sum, ab_sum[ROT_W-1:0]);

    // Subkey ring control.
    always_comb
    begin
        ring_ctrl.mode   = SHIFT_HOLD;
        ring_ctrl.insert = 1'b0;
        ring_ins         = wa_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                ring_ctrl.mode   = SHIFT_FWD;
                ring_ctrl.insert = 1'b1;
                ring_ins         = gen_reg;
            end
            ST_MIX_B:
            begin
                ring_ctrl.mode   = SHIFT_FWD;
                ring_ctrl.insert = 1'b1;
            end
            ST_RUN:
            begin
                if (advance)
                    ring_ctrl.mode = func_reg ? SHIFT_BACK : SHIFT_FWD;
            end
            default: ;
        endcase
    end

    rc5_subkey_ring #(
        .DEPTH (N)
    ) u_ring (
        .clk       (clk),
        .ctrl      (ring_ctrl),
        .ins_word  (ring_ins),
        .head_word (head_word),
        .tail_word (tail_word)
    );

    // Sequencer: table fill, key mixing, then block rounds.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gen_next       = gen_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        func_next      = func_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        for (int i = 0; i < KEY_WORDS; i++)
            kw_next[i] = kw_reg[i];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    wa_next    = s_tdata[31:0];
                    wb_next    = s_tdata[63:32];
                    func_next  = s_tuser[0];
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_FILL:
            begin
                gen_next = gen_reg + MAGIC_Q;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST_RUN)
                begin
                    cnt_next   = '0;
                    wa_next    = '0;
                    wb_next    = '0;
                    kw_next[0] = key_lo_reg[31:0];
                    kw_next[1] = key_lo_reg[63:32];
                    kw_next[2] = key_hi_reg[31:0];
                    kw_next[3] = key_hi_reg[63:32];
                    state_next = ST_MIX_A;
                end
            end
            ST_MIX_A:
            begin
                wa_next    = mix_a;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                wb_next = mix_b;
                for (int i = 0; i < KEY_WORDS - 1; i++)
                    kw_next[i] = kw_reg[i+1];
                kw_next[KEY_WORDS-1] = mix_b;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_MIX_A;
                if (cnt_reg == CNT_LAST_MIX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    wa_next  = rd_a;
                    wb_next  = rd_b;
                    cnt_next = cnt_reg + 1'b1;
                    if (run_last)
                    begin
                        out_data_next  = {rd_b, rd_a};
                        out_valid_next = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // A key write restarts the schedule from the magic constant fill.
        if (cfg_hit)
        begin
            state_next = ST_FILL;
            cnt_next   = '0;
            gen_next   = MAGIC_P;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            gen_reg       <= MAGIC_P;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        func_reg     <= func_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < KEY_WORDS; i++)
            kw_reg[i] <= kw_next[i];
    end

    // A result only appears at the end of a round sequence.
    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result appeared outside the round sequence");

    // A key write always restarts the key schedule.
    a_key_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (state_reg == ST_FILL) && (cnt_reg == '0))
        else $error("key write did not restart the schedule");

    // An accepted block starts its rounds at the first subkey.
    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_RUN) && (cnt_reg == '0))
        else $error("accepted block did not start its rounds");

    // The round step count stays inside the subkey table.
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= CNT_LAST_RUN))
        else $error("round step count out of range");

endmodule

`default_nettype wire

@@ hdl/rc5_cell.sv @@
`default_nettype none

module rc5_cell
    import rc5_pkg::*;
(
    input  wire logic              clk,
    input  wire shift_mode_t       mode,
    input  wire logic [WORD_W-1:0] from_next,
    input  wire logic [WORD_W-1:0] from_prev,
    output logic      [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;

    // One subkey word; it takes its neighbor's word when the ring moves.
    always_ff @(posedge clk)
    begin
        case (mode)
            SHIFT_FWD:  word_reg <= from_next;
            SHIFT_BACK: word_reg <= from_prev;
            default:    word_reg <= word_reg;
        endcase
    end

    assign word = word_reg;

endmodule

`default_nettype wire

@@ hdl/rc5_subkey_ring.sv @@
`default_nettype none

module rc5_subkey_ring
    import rc5_pkg::*;
#(
    parameter int DEPTH = 26
)
(
    input  wire logic              clk,
    input  wire ring_ctrl_t        ctrl,
    input  wire logic [WORD_W-1:0] ins_word,
    output logic      [WORD_W-1:0] head_word,
    output logic      [WORD_W-1:0] tail_word
);

    logic [WORD_W-1:0] words [DEPTH];

    // A ring of cells. Forward moves hand each word one place toward the
    // head, the head word wrapping to the tail unless a new word is inserted.
    // Backward moves hand each word one place toward the tail.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] nxt;
        logic [WORD_W-1:0] prv;

        if (i == DEPTH - 1)
        begin : g_tail
            assign nxt = ctrl.insert ? ins_word : words[0];
        end
        else
        begin : g_mid
            assign nxt = words[i+1];
        end

        if (i == 0)
        begin : g_head
            assign prv = words[DEPTH-1];
        end
        else
        begin : g_rest
            assign prv = words[i-1];
        end

        rc5_cell u_cell (
            .clk       (clk),
            .mode      (ctrl.mode),
            .from_next (nxt),
            .from_prev (prv),
            .word      (words[i])
        );
    end

    assign head_word = words[0];
    assign tail_word = words[DEPTH-1];

endmodule

`default_nettype wire
